// ----- rtl/ucd_pkg.sv -----
// shared types and constants for the utf-8 code point decoder
package ucd_pkg;

   localparam int CP_WIDTH    = 21;
   localparam int BITS_WIDTH  = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_WIDTH-1:0] REPL_CHAR = 21'h00FFFD;
   localparam logic [CP_WIDTH-1:0] MIN_CP_2  = 21'h000080;
   localparam logic [CP_WIDTH-1:0] MIN_CP_3  = 21'h000800;
   localparam logic [CP_WIDTH-1:0] MIN_CP_4  = 21'h010000;
   localparam logic [CP_WIDTH-1:0] SURR_LO   = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURR_HI   = 21'h00DFFF;
   localparam logic [CP_WIDTH-1:0] CP_MAX    = 21'h10FFFF;

   // byte class found by the front end
   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_CONT,
      CLS_BAD
   } byte_class_type;

   // classified byte as it sits in the queue
   typedef struct packed {
      byte_class_type          cls;
      logic [BITS_WIDTH-1:0]   bits;
      logic                    last;
   } byte_rec_type;

endpackage

// ----- rtl/ucd_req_if.sv -----
// byte input channel
interface ucd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_of_string;

   modport source (output valid, output byte_in, output last_of_string, input ready);
   modport sink   (input valid, input byte_in, input last_of_string, output ready);
endinterface

// ----- rtl/ucd_rsp_if.sv -----
// code point result channel
interface ucd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ucd_pkg::CP_WIDTH-1:0]  code_point;
   logic                          replaced;

   modport source (output valid, output code_point, output replaced, input ready);
   modport sink   (input valid, input code_point, input replaced, output ready);
endinterface

// ----- rtl/ucd_front.sv -----
// front end: byte classification and the queue toward the decoder
module ucd_front (
   input  logic                  clock,
   input  logic                  reset,
   ucd_req_if.sink               req_ch,
   output logic                  head_valid,
   output ucd_pkg::byte_rec_type head_rec,
   input  logic                  head_pop
);

   ucd_pkg::byte_rec_type                      queue_ff [ucd_pkg::QUEUE_DEPTH];
   logic [ucd_pkg::QPTR_WIDTH-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [ucd_pkg::QPTR_WIDTH-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [ucd_pkg::QCNT_WIDTH-1:0]             count_ff, count_in;
   ucd_pkg::byte_rec_type                      new_rec;
   logic                                       push;
   logic                                       pop;

   // classify the incoming byte by its lead bits
   always_comb begin
      new_rec.last = req_ch.last_of_string;
      new_rec.bits = req_ch.byte_in[6:0];
      if (req_ch.byte_in[7] == 1'b0) begin
         new_rec.cls  = ucd_pkg::CLS_ASCII;
      end else if (req_ch.byte_in[7:6] == 2'b10) begin
         new_rec.cls  = ucd_pkg::CLS_CONT;
         new_rec.bits = {1'b0, req_ch.byte_in[5:0]};
      end else if (req_ch.byte_in[7:5] == 3'b110) begin
         new_rec.cls  = ucd_pkg::CLS_LEAD2;
         new_rec.bits = {2'b0, req_ch.byte_in[4:0]};
      end else if (req_ch.byte_in[7:4] == 4'b1110) begin
         new_rec.cls  = ucd_pkg::CLS_LEAD3;
         new_rec.bits = {3'b0, req_ch.byte_in[3:0]};
      end else if (req_ch.byte_in[7:3] == 5'b11110) begin
         new_rec.cls  = ucd_pkg::CLS_LEAD4;
         new_rec.bits = {4'b0, req_ch.byte_in[2:0]};
      end else begin
         new_rec.cls  = ucd_pkg::CLS_BAD;
      end
   end

   // queue handshake
   assign req_ch.ready = (count_ff != ucd_pkg::QCNT_WIDTH'(ucd_pkg::QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = head_pop && head_valid;
   assign head_valid   = (count_ff != '0);
   assign head_rec     = queue_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_rec;
      end
   end

endmodule

// ----- rtl/ucd_back.sv -----
// back end: sequence assembly, range checks and the result register
module ucd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ucd_pkg::byte_rec_type head_rec,
   output logic                  head_pop,
   ucd_rsp_if.source             rsp_ch
);

   logic [1:0]                    pending_ff, pending_in;
   logic [1:0]                    seqlen_ff, seqlen_in;
   logic [ucd_pkg::CP_WIDTH-1:0]  partial_ff, partial_in;
   logic                          skip_ff, skip_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ucd_pkg::CP_WIDTH-1:0]  rsp_cp_ff, rsp_cp_in;
   logic                          rsp_rep_ff, rsp_rep_in;
   logic                          out_free;
   logic                          emit;
   logic [ucd_pkg::CP_WIDTH-1:0]  emit_cp;
   logic                          emit_rep;
   logic [ucd_pkg::CP_WIDTH-1:0]  shifted;
   logic [1:0]                    pending_dec;
   logic [ucd_pkg::CP_WIDTH-1:0]  min_cp;
   logic                          out_of_range;

   // take the next item when the result register can hold what it gives
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign head_pop = head_valid && out_free;

   // assembled value and its checks
   assign shifted     = {partial_ff[ucd_pkg::CP_WIDTH-7:0], head_rec.bits[5:0]};
   assign pending_dec = pending_ff - 2'd1;

   always_comb begin
      case (seqlen_ff)
         2'd1:    min_cp = ucd_pkg::MIN_CP_2;
         2'd2:    min_cp = ucd_pkg::MIN_CP_3;
         default: min_cp = ucd_pkg::MIN_CP_4;
      endcase
   end

   assign out_of_range = (shifted < min_cp) || (shifted > ucd_pkg::CP_MAX) ||
                         ((shifted >= ucd_pkg::SURR_LO) && (shifted <= ucd_pkg::SURR_HI));

   // decode step for the item at the head of the queue
   always_comb begin
      pending_in = pending_ff;
      seqlen_in  = seqlen_ff;
      partial_in = partial_ff;
      skip_in    = skip_ff;
      emit       = 1'b0;
      emit_cp    = ucd_pkg::REPL_CHAR;
      emit_rep   = 1'b1;
      if (skip_ff) begin
         // dropping bytes up to the end of the string
         if (head_rec.last) begin
            skip_in = 1'b0;
         end
      end else if (pending_ff == 2'd0) begin
         // lead byte
         pending_in = 2'd0;
         seqlen_in  = 2'd0;
         partial_in = '0;
         unique case (head_rec.cls)
            ucd_pkg::CLS_ASCII: begin
               emit     = 1'b1;
               emit_cp  = ucd_pkg::CP_WIDTH'(head_rec.bits);
               emit_rep = 1'b0;
            end
            ucd_pkg::CLS_LEAD2, ucd_pkg::CLS_LEAD3, ucd_pkg::CLS_LEAD4: begin
               if (head_rec.last) begin
                  emit = 1'b1;
               end else begin
                  if (head_rec.cls == ucd_pkg::CLS_LEAD2) begin
                     pending_in = 2'd1;
                  end else if (head_rec.cls == ucd_pkg::CLS_LEAD3) begin
                     pending_in = 2'd2;
                  end else begin
                     pending_in = 2'd3;
                  end
                  seqlen_in  = pending_in;
                  partial_in = ucd_pkg::CP_WIDTH'(head_rec.bits);
               end
            end
            default: begin
               emit = 1'b1;
            end
         endcase
      end else if (head_rec.cls != ucd_pkg::CLS_CONT) begin
         // broken sequence: one replacement, then drop the rest of the string
         emit       = 1'b1;
         pending_in = 2'd0;
         seqlen_in  = 2'd0;
         partial_in = '0;
         skip_in    = !head_rec.last;
      end else if (pending_dec != 2'd0) begin
         // more continuation bytes to come
         if (head_rec.last) begin
            emit       = 1'b1;
            pending_in = 2'd0;
            seqlen_in  = 2'd0;
            partial_in = '0;
         end else begin
            pending_in = pending_dec;
            partial_in = shifted;
         end
      end else begin
         // sequence complete
         emit       = 1'b1;
         pending_in = 2'd0;
         seqlen_in  = 2'd0;
         partial_in = '0;
         if (!out_of_range) begin
            emit_cp  = shifted;
            emit_rep = 1'b0;
         end
      end
   end

   // result register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cp_in    = rsp_cp_ff;
      rsp_rep_in   = rsp_rep_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (head_pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_cp_in    = emit_cp;
         rsp_rep_in   = emit_rep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 2'd0;
         seqlen_ff    <= 2'd0;
         partial_ff   <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (head_pop) begin
            pending_ff <= pending_in;
            seqlen_ff  <= seqlen_in;
            partial_ff <= partial_in;
            skip_ff    <= skip_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cp_ff  <= rsp_cp_in;
      rsp_rep_ff <= rsp_rep_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.code_point = rsp_cp_ff;
   assign rsp_ch.replaced   = rsp_rep_ff;

   // dropping mode never overlaps an open sequence
   a_skip_no_pending: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (pending_ff == 2'd0))
      else $error("skip mode with continuation bytes pending");

   // bytes still expected never exceed the sequence length
   a_pending_in_seq: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != 2'd0) |-> ((seqlen_ff != 2'd0) && (pending_ff <= seqlen_ff)))
      else $error("pending count outside the open sequence");

   // a new result appears only from an item taken off the queue
   a_result_from_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(head_pop))
      else $error("result without a decoded item");

endmodule

// ----- rtl/utf8_codepoint_decoder.sv -----
// top level of the utf-8 code point decoder
// Takes one byte of a UTF-8 string per cycle on req_ch, with last_of_string on the
// final byte of each string, and gives one code point on rsp_ch per complete
// sequence, with U+FFFD and replaced set for malformed input. A byte is taken
// every cycle as long as the two-entry queue between the classifier and the
// decoder has room; the decoder retires one queued byte per cycle into the
// result register whenever that register is empty or being read. The byte
// that completes a result is first written into the queue; the result
// register is written when the decoder takes that byte off the queue. The
// queue lets input keep flowing for two bytes while the result side is stalled.
module utf8_codepoint_decoder (
   input  logic       clock,
   input  logic       reset,
   ucd_req_if.sink    req_ch,
   ucd_rsp_if.source  rsp_ch
);

   logic                  head_valid;
   ucd_pkg::byte_rec_type head_rec;
   logic                  head_pop;

   // classifier and queue
   ucd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .head_pop   (head_pop)
   );

   // sequence decoder and result register
   ucd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .head_pop   (head_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
